/* hdl/stt_pkg.sv */
// Shared types, character constants and byte classification for the
// source text tokenizer. No dependencies.
`default_nettype none

package stt_pkg;

  localparam int unsigned POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_US    = 8'h5F;  // '_'
  localparam logic [7:0] CH_NL    = 8'h0A;  // newline
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
  localparam logic [7:0] CH_SQ    = 8'h27;  // single quote
  localparam logic [7:0] CH_LOW_N = 8'h6E;  // 'n'
  localparam logic [7:0] CH_LOW_T = 8'h74;  // 't'
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    KIND_ID  = 2'd0,
    KIND_NUM = 2'd1,
    KIND_STR = 2'd2,
    KIND_SYM = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CLS_SKIP  = 3'd0,
    CLS_ID    = 3'd1,
    CLS_DIGIT = 3'd2,
    CLS_SYM   = 3'd3,
    CLS_QUOTE = 3'd4
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       end_of_text;
  } stt_in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          tok_char;
    logic                char_present;
    logic                first;
    logic                last;
    logic [POS_BITS-1:0] start_line;
    logic [POS_BITS-1:0] start_column;
  } stt_out_t;

  // zero, one or two results made by one input transfer
  typedef struct packed {
    logic [1:0]         count;
    stt_out_t [1:0]     item;
  } stt_push_t;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e c;
    c = CLS_SKIP;
    if ((b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]}) || b == CH_US) begin
      c = CLS_ID;
    end else if (b inside {[8'h30:8'h39]}) begin
      c = CLS_DIGIT;
    end else if (b == CH_DQ || b == CH_SQ) begin
      c = CLS_QUOTE;
    end else if (b inside {8'h2C, 8'h2E, 8'h3C, 8'h3E, 8'h21, 8'h40, 8'h23, 8'h24,
                           8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h7B, 8'h7D,
                           8'h2F, 8'h5C, 8'h3A, 8'h3B, 8'h60, 8'h3D, 8'h7E, 8'h7C,
                           8'h2B, 8'h2D}) begin
      c = CLS_SYM;
    end
    return c;
  endfunction

  // brackets and punctuation never combine with a second symbol
  function automatic logic pairable(input logic [7:0] b);
    return !(b inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3B, 8'h3A, 8'h60, 8'h7E});
  endfunction

  function automatic stt_out_t mk_result(input kind_e k, input logic [7:0] c,
                                         input logic present, input logic first,
                                         input logic last, input logic [POS_BITS-1:0] line,
                                         input logic [POS_BITS-1:0] column);
    stt_out_t r;
    r.kind         = k;
    r.tok_char     = c;
    r.char_present = present;
    r.first        = first;
    r.last         = last;
    r.start_line   = line;
    r.start_column = column;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/stt_scan.sv */
// Scanner: holds the tokenizer state and turns one input transfer into
// zero, one or two result items. Depends on stt_pkg.
`default_nettype none

module stt_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire stt_pkg::stt_in_t  in_data_i,
  output stt_pkg::stt_push_t     push_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_ID   = 3'd1;
  localparam logic [2:0] M_NUM  = 3'd2;
  localparam logic [2:0] M_STR  = 3'd3;
  localparam logic [2:0] M_ESC  = 3'd4;
  localparam logic [2:0] M_SYM  = 3'd5;

  logic [2:0]                   mode_q, mode_d;
  logic [7:0]                   held_char_q, held_char_d;
  logic                         held_valid_q, held_valid_d;
  logic                         held_first_q, held_first_d;
  logic [stt_pkg::POS_BITS-1:0] cur_line_q, cur_line_d;
  logic [stt_pkg::POS_BITS-1:0] cur_col_q, cur_col_d;
  logic [stt_pkg::POS_BITS-1:0] tok_line_q, tok_line_d;
  logic [stt_pkg::POS_BITS-1:0] tok_col_q, tok_col_d;

  logic [7:0]        b;
  stt_pkg::cls_e     cls;
  stt_pkg::kind_e    kind;
  logic              more;
  logic              start;
  logic [1:0]        nres;
  stt_pkg::stt_out_t res [2];

  always_comb begin
    mode_d       = mode_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    tok_line_d   = tok_line_q;
    tok_col_d    = tok_col_q;
    nres         = 2'd0;
    res[0]       = '0;
    res[1]       = '0;
    b            = in_data_i.ch;
    cls          = stt_pkg::classify(b);
    kind         = (mode_q == M_ID) ? stt_pkg::KIND_ID : stt_pkg::KIND_NUM;
    more         = 1'b0;
    start        = 1'b0;

    if (accept_i && in_data_i.ch_valid) begin
      case (mode_q)
        M_ID, M_NUM: begin
          more = (mode_q == M_ID) ? (cls == stt_pkg::CLS_ID || cls == stt_pkg::CLS_DIGIT)
                                  : (cls == stt_pkg::CLS_DIGIT || b == stt_pkg::CH_DOT);
          res[nres[0]] = stt_pkg::mk_result(kind, held_char_d, 1'b1, held_first_d, !more,
                                            tok_line_d, tok_col_d);
          nres = nres + 2'd1;
          if (more) begin
            held_char_d  = b;
            held_valid_d = 1'b1;
            held_first_d = 1'b0;
          end else begin
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
            start        = 1'b1;
          end
        end
        M_SYM: begin
          if (stt_pkg::pairable(held_char_d) && (b == held_char_d || b == stt_pkg::CH_EQ)) begin
            res[0] = stt_pkg::mk_result(stt_pkg::KIND_SYM, held_char_d, 1'b1, 1'b1, 1'b0,
                                        tok_line_d, tok_col_d);
            res[1] = stt_pkg::mk_result(stt_pkg::KIND_SYM, b, 1'b1, 1'b0, 1'b1,
                                        tok_line_d, tok_col_d);
            nres   = 2'd2;
          end else begin
            res[0] = stt_pkg::mk_result(stt_pkg::KIND_SYM, held_char_d, 1'b1, 1'b1, 1'b1,
                                        tok_line_d, tok_col_d);
            nres   = 2'd1;
            start  = 1'b1;
          end
          held_valid_d = 1'b0;
          mode_d       = M_IDLE;
        end
        M_STR, M_ESC: begin
          if (mode_q == M_STR && (cls == stt_pkg::CLS_QUOTE || b == stt_pkg::CH_NUL)) begin
            // closing quote or NUL byte: last byte or the empty-string marker
            if (held_valid_d) begin
              res[0] = stt_pkg::mk_result(stt_pkg::KIND_STR, held_char_d, 1'b1,
                                          held_first_d, 1'b1, tok_line_d, tok_col_d);
            end else begin
              res[0] = stt_pkg::mk_result(stt_pkg::KIND_STR, stt_pkg::CH_NUL, 1'b0,
                                          1'b1, 1'b1, tok_line_d, tok_col_d);
            end
            nres         = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
          end else if (mode_q == M_STR && b == stt_pkg::CH_BSL) begin
            mode_d = M_ESC;
          end else begin
            mode_d = M_STR;
            more   = 1'b1;
            if (mode_q == M_ESC) begin
              // escape translation; unknown escapes are dropped
              case (b)
                stt_pkg::CH_BSL:   b = stt_pkg::CH_BSL;
                stt_pkg::CH_LOW_N: b = stt_pkg::CH_NL;
                stt_pkg::CH_LOW_T: b = stt_pkg::CH_TAB;
                stt_pkg::CH_DQ:    b = stt_pkg::CH_DQ;
                default:           more = 1'b0;
              endcase
            end
            if (more) begin
              if (held_valid_d) begin
                res[0] = stt_pkg::mk_result(stt_pkg::KIND_STR, held_char_d, 1'b1,
                                            held_first_d, 1'b0, tok_line_d, tok_col_d);
                nres   = 2'd1;
              end
              held_first_d = !held_valid_d;
              held_char_d  = b;
              held_valid_d = 1'b1;
            end
          end
        end
        default: begin
          mode_d       = M_IDLE;
          held_valid_d = 1'b0;
          start        = 1'b1;
        end
      endcase

      if (start && cls != stt_pkg::CLS_SKIP) begin
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
        if (cls == stt_pkg::CLS_QUOTE) begin
          mode_d       = M_STR;
          held_valid_d = 1'b0;
          held_first_d = 1'b0;
        end else begin
          mode_d       = (cls == stt_pkg::CLS_ID) ? M_ID :
                         ((cls == stt_pkg::CLS_DIGIT) ? M_NUM : M_SYM);
          held_char_d  = in_data_i.ch;
          held_valid_d = 1'b1;
          held_first_d = 1'b1;
        end
      end

      if (in_data_i.ch == stt_pkg::CH_NL) begin
        if (cur_line_q != stt_pkg::POS_MAX) begin
          cur_line_d = cur_line_q + stt_pkg::POS_ONE;
        end
        cur_col_d = stt_pkg::POS_ONE;
      end else if (cur_col_q != stt_pkg::POS_MAX) begin
        cur_col_d = cur_col_q + stt_pkg::POS_ONE;
      end
    end

    if (accept_i && in_data_i.end_of_text) begin
      // flush whatever token is still open
      if (nres != 2'd2) begin
        case (mode_d)
          M_ID, M_NUM: begin
            res[nres[0]] = stt_pkg::mk_result(
                (mode_d == M_ID) ? stt_pkg::KIND_ID : stt_pkg::KIND_NUM, held_char_d,
                1'b1, held_first_d, 1'b1, tok_line_d, tok_col_d);
            nres = nres + 2'd1;
          end
          M_SYM: begin
            res[nres[0]] = stt_pkg::mk_result(stt_pkg::KIND_SYM, held_char_d, 1'b1, 1'b1,
                                              1'b1, tok_line_d, tok_col_d);
            nres = nres + 2'd1;
          end
          M_STR, M_ESC: begin
            if (held_valid_d) begin
              res[nres[0]] = stt_pkg::mk_result(stt_pkg::KIND_STR, held_char_d, 1'b1,
                                                held_first_d, 1'b1, tok_line_d, tok_col_d);
            end else begin
              res[nres[0]] = stt_pkg::mk_result(stt_pkg::KIND_STR, stt_pkg::CH_NUL, 1'b0,
                                                1'b1, 1'b1, tok_line_d, tok_col_d);
            end
            nres = nres + 2'd1;
          end
          default: begin
          end
        endcase
      end
      mode_d       = M_IDLE;
      held_valid_d = 1'b0;
      held_first_d = 1'b0;
      cur_line_d   = stt_pkg::POS_ONE;
      cur_col_d    = stt_pkg::POS_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      cur_line_q   <= stt_pkg::POS_ONE;
      cur_col_q    <= stt_pkg::POS_ONE;
      tok_line_q   <= stt_pkg::POS_ONE;
      tok_col_q    <= stt_pkg::POS_ONE;
    end else begin
      mode_q       <= mode_d;
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      held_first_q <= held_first_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      tok_line_q   <= tok_line_d;
      tok_col_q    <= tok_col_d;
    end
  end

  assign push_o.count   = nres;
  assign push_o.item[0] = res[0];
  assign push_o.item[1] = res[1];

endmodule

`default_nettype wire

/* hdl/stt_outq.sv */
// Four-entry result queue: takes up to two results per cycle from the
// scanner and, when popped, presents one per cycle. Depends on stt_pkg.
`default_nettype none

module stt_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stt_pkg::stt_push_t push_i,
  input  wire logic               pop_i,
  output logic                    room_o,
  output logic                    valid_o,
  output stt_pkg::stt_out_t       data_o
);

  stt_pkg::stt_out_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] wr_next;

  assign wr_next  = wr_ptr_q + 2'd1;
  assign wr_ptr_d = wr_ptr_q + push_i.count;
  assign rd_ptr_d = rd_ptr_q + {1'b0, pop_i};
  assign count_d  = count_q + {1'b0, push_i.count} - {2'b00, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.item[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.item[1];
    end
  end

  // keep room for the worst case of two results from one transfer
  assign room_o  = count_q <= 3'd2;
  assign valid_o = count_q != 3'd0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/source_text_tokenizer_core.sv */
// Top level of the source text tokenizer: scanner plus result queue.
// Depends on stt_pkg, stt_scan and stt_outq.
//
// Input channel: one source byte (with ch_valid) and/or an end-of-text
// flag per transfer. Output channel: one token byte per transfer with kind,
// first/last marks and the token's start line and column.
// Token bytes leave one input byte late, since the last mark of a byte is
// known only when the next byte arrives; end_of_text flushes the open token.
// An input transfer makes zero, one or two results; they are written into a
// four-entry queue and set out_valid_o the cycle after the input transfer.
// The scanner takes one byte per cycle, the output one result per cycle while
// the receiver is ready; a two-result transfer always leaves the scanner idle,
// so two never follow each other and a ready receiver never stalls input.
// in_stall_o rises when fewer than two queue entries are free, so it comes
// from the queue fill level only. A stalling receiver fills the queue and
// then stalls the input; nothing is lost or repeated.
// Reset empties the queue and returns the scanner to idle at line 1,
// column 1.
`default_nettype none

module source_text_tokenizer_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire stt_pkg::stt_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output stt_pkg::stt_out_t      out_data_o
);

  stt_pkg::stt_push_t push;
  logic               room;
  logic               in_xfer;
  logic               out_xfer;

  assign in_stall_o = !room;
  assign in_xfer    = in_valid_i && room;
  assign out_xfer   = out_valid_o && !out_stall_i;

  stt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .in_data_i(in_data_i),
    .push_o   (push)
  );

  stt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_xfer),
    .room_o (room),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  a_push_needs_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |-> in_xfer)
    else $error("results produced without an input transfer");

  a_push_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd3)
    else $error("scanner produced more than two results");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |=> out_valid_o)
    else $error("queued result not presented");

  a_empty_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.char_present |->
      out_data_o.first && out_data_o.last && out_data_o.kind == stt_pkg::KIND_STR)
    else $error("byte-less result that is not a lone empty string");

endmodule

`default_nettype wire
